/* design/bliu_pkg.sv */
// ----------------------------------------------------------------------------
// bliu_pkg
// Shared types and constants of the bilinear image upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bliu_pkg;

  localparam int PIX_W      = 16;
  localparam int FRAC_BITS  = 7;
  localparam int WEIGHT_W   = FRAC_BITS + 1;          // weights run 0..2^FRAC_BITS
  localparam int ACC_W      = PIX_W + WEIGHT_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_BITS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_HEIGHT,
    REG_SRC_WIDTH,
    REG_CHAN_COUNT,
    REG_DEST_HEIGHT,
    REG_DEST_WIDTH,
    REG_ROW_SHIFT,
    REG_COL_SHIFT
  } cfg_reg_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic                en;
    logic                clear;
    logic [WEIGHT_W-1:0] weight;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* design/bilinear_image_upscaler_top.sv */
// ----------------------------------------------------------------------------
// bilinear_image_upscaler_top
// Planar source image store plus bilinear interpolation of requested pixels.
// ----------------------------------------------------------------------------
// A write lands in the image store from the decode state after accept. A
//   request passes decode and the run steps before its result is registered
//   (decode only if out of range). A new item is accepted only once the last
//   is through. A request makes four reads on the single image port and six
//   passes through the one multiply-accumulate unit (two horizontal blends,
//   one vertical blend). A held result stalls the next request at its end.
// Reset: rst_n is synchronous, active low; configuration returns to its
//   defaults, the image store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_upscaler_top
  import bliu_pkg::*;
#(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_HEIGHT   = 128,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  // Input items
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [1:0] channel, [11:2] row, [21:12] col, [37:22] pixel_in, [39:38] zero
  input  wire logic [39:0]           in_tdata,
  // [0] operation
  input  wire logic [0:0]            in_tuser,

  // Result items
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] pixel_out
  output logic [15:0]                out_tdata,
  // [0] status
  output logic [0:0]                 out_tuser,

  // Configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PLANE = MAX_HEIGHT * MAX_WIDTH;
  localparam int DEPTH = MAX_CHANNELS * PLANE;
  localparam int AW    = $clog2(DEPTH);

  // Sequencer steps inside ST_RUN. Reads go out on steps 0..3, read data and
  // MAC passes follow in the step after.
  localparam logic [2:0] STEP_FIRST      = 3'd0;
  localparam logic [2:0] STEP_TOP        = 3'd2;
  localparam logic [2:0] STEP_LAST_READ  = 3'd3;
  localparam logic [2:0] STEP_BOTTOM     = 3'd4;
  localparam logic [2:0] STEP_VERT_FIRST = 3'd5;
  localparam logic [2:0] STEP_RESULT     = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes take effect at once. Software is to write
  // them only while the block is idle; the block itself does not enforce it.
  // --------------------------------------------------------------------------
  logic [7:0]  src_h_r, src_w_r;
  logic [2:0]  chan_cnt_r;
  logic [10:0] dest_h_r, dest_w_r;
  logic [2:0]  row_shift_r, col_shift_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_h_r     <= 8'd112;
      src_w_r     <= 8'd88;
      chan_cnt_r  <= 3'd1;
      dest_h_r    <= 11'd224;
      dest_w_r    <= 11'd176;
      row_shift_r <= 3'd1;
      col_shift_r <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_HEIGHT:  src_h_r     <= cfg_data[7:0];
        REG_SRC_WIDTH:   src_w_r     <= cfg_data[7:0];
        REG_CHAN_COUNT:  chan_cnt_r  <= cfg_data[2:0];
        REG_DEST_HEIGHT: dest_h_r    <= cfg_data;
        REG_DEST_WIDTH:  dest_w_r    <= cfg_data;
        REG_ROW_SHIFT:   row_shift_r <= cfg_data[2:0];
        REG_COL_SHIFT:   col_shift_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Sizes in use, saturated to the storage limits.
  logic [10:0] sh_eff, sw_eff;
  logic [4:0]  nc_eff;

  assign sh_eff = (src_h_r > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : {3'b000, src_h_r};
  assign sw_eff = (src_w_r > MAX_WIDTH) ? 11'(MAX_WIDTH) : {3'b000, src_w_r};
  assign nc_eff = (chan_cnt_r > MAX_CHANNELS) ? 5'(MAX_CHANNELS)
                                              : {2'b00, chan_cnt_r};

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [2:0]              step_r, step_nxt;

  logic                    op_r;
  logic [1:0]              chan_r;
  logic [9:0]              row_r, col_r;
  logic signed [PIX_W-1:0] pix_in_r;

  logic [9:0]              y0_r, y1_r, x0_r, x1_r;
  logic [FRAC_BITS-1:0]    fy_r, fx_r;
  logic signed [PIX_W-1:0] top_r, bottom_r;

  logic                    out_tvalid_r, out_tvalid_nxt;
  logic signed [PIX_W-1:0] out_pix_r;
  logic                    out_status_r;

  logic                    in_fire;
  logic                    out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_status_r;

  // --------------------------------------------------------------------------
  // Decode of the held item: range checks and source position.
  // --------------------------------------------------------------------------
  logic                 wr_ok;
  logic                 dest_bad, src_bad;
  logic [16:0]          pos_y_full, pos_x_full;
  logic [15:0]          pos_y, pos_x;
  logic [10:0]          y0_ext, x0_ext;
  logic [10:0]          y0_inc, x0_inc;
  logic [10:0]          y_last, x_last;
  logic [10:0]          y1_calc, x1_calc;

  always_comb begin
    wr_ok = ({3'b000, chan_r} < nc_eff) && ({1'b0, row_r} < sh_eff)
            && ({1'b0, col_r} < sw_eff);
    dest_bad = ({3'b000, chan_r} >= nc_eff) || ({1'b0, row_r} >= dest_h_r)
               || ({1'b0, col_r} >= dest_w_r);

    // position wraps at 16 bits
    pos_y_full = {row_r, {FRAC_BITS{1'b0}}} >> row_shift_r;
    pos_x_full = {col_r, {FRAC_BITS{1'b0}}} >> col_shift_r;
    pos_y      = pos_y_full[15:0];
    pos_x      = pos_x_full[15:0];

    y0_ext  = {2'b00, pos_y[15:FRAC_BITS]};
    x0_ext  = {2'b00, pos_x[15:FRAC_BITS]};
    src_bad = (y0_ext >= sh_eff) || (x0_ext >= sw_eff);

    // neighbor clamped to the last row / column in use
    y0_inc  = y0_ext + 11'd1;
    x0_inc  = x0_ext + 11'd1;
    y_last  = sh_eff - 11'd1;
    x_last  = sw_eff - 11'd1;
    y1_calc = (y0_inc < y_last) ? y0_inc : y_last;
    x1_calc = (x0_inc < x_last) ? x0_inc : x_last;
  end

  // --------------------------------------------------------------------------
  // Image store port
  // --------------------------------------------------------------------------
  function automatic logic [AW-1:0] pix_addr(input logic [1:0] c,
                                             input logic [9:0] y,
                                             input logic [9:0] x);
    return AW'(int'(c) * PLANE + int'(y) * MAX_WIDTH + int'(x));
  endfunction

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_addr;
  logic signed [PIX_W-1:0] ram_rdata;

  always_comb begin
    ram_we = (state_r == ST_DECODE) && (op_r == OP_WRITE) && wr_ok;
    ram_re = (state_r == ST_RUN) && (step_r <= STEP_LAST_READ);
    if (state_r == ST_DECODE) begin
      ram_addr = pix_addr(chan_r, row_r, col_r);
    end else begin
      // order: (y0,x0) (y0,x1) (y1,x0) (y1,x1)
      ram_addr = pix_addr(chan_r, step_r[1] ? y1_r : y0_r, step_r[0] ? x1_r : x0_r);
    end
  end

  bliu_image_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (pix_in_r),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared MAC. Odd steps start a fresh sum with the near-sample weight,
  // even steps add the far sample and yield a blend. The last pass is not
  // stored, so the result holds steady while the output is stalled.
  // --------------------------------------------------------------------------
  mac_ctrl_t               mac_ctrl;
  logic signed [PIX_W-1:0] mac_sample;
  logic signed [PIX_W-1:0] mac_blend;
  logic [WEIGHT_W-1:0]     wx_far, wy_far;

  always_comb begin
    wx_far = {1'b0, fx_r};
    wy_far = {1'b0, fy_r};
    mac_ctrl.en    = (state_r == ST_RUN) && (step_r != STEP_FIRST)
                     && (step_r != STEP_RESULT);
    mac_ctrl.clear = step_r[0];
    if (step_r <= STEP_BOTTOM) begin
      mac_ctrl.weight = step_r[0] ? (WEIGHT_ONE - wx_far) : wx_far;
      mac_sample      = ram_rdata;
    end else if (step_r == STEP_VERT_FIRST) begin
      mac_ctrl.weight = WEIGHT_ONE - wy_far;
      mac_sample      = top_r;
    end else begin
      mac_ctrl.weight = wy_far;
      mac_sample      = bottom_r;
    end
  end

  bliu_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .sample (mac_sample),
    .blend  (mac_blend)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic                    load_out;
  logic signed [PIX_W-1:0] load_pix;
  logic                    load_status;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    load_out    = 1'b0;
    load_pix    = '0;
    load_status = STATUS_RANGE;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (op_r == OP_WRITE) begin
          state_nxt = ST_IDLE;
        end else if (dest_bad || src_bad) begin
          // flagged request: zero pixel, hold here until the output frees up
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_RUN;
          step_nxt  = STEP_FIRST;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_RESULT) begin
          if (out_free) begin
            load_out    = 1'b1;
            load_pix    = mac_blend;
            load_status = STATUS_OK;
            state_nxt   = ST_IDLE;
          end
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_tvalid_nxt = load_out || (out_tvalid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STEP_FIRST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end

    if (in_fire) begin
      op_r     <= in_tuser[0];
      chan_r   <= in_tdata[1:0];
      row_r    <= in_tdata[11:2];
      col_r    <= in_tdata[21:12];
      pix_in_r <= in_tdata[37:22];
    end

    if (state_r == ST_DECODE) begin
      y0_r <= y0_ext[9:0];
      x0_r <= x0_ext[9:0];
      y1_r <= y1_calc[9:0];
      x1_r <= x1_calc[9:0];
      fy_r <= pos_y[FRAC_BITS-1:0];
      fx_r <= pos_x[FRAC_BITS-1:0];
    end

    if (state_r == ST_RUN && step_r == STEP_TOP) begin
      top_r <= mac_blend;
    end
    if (state_r == ST_RUN && step_r == STEP_BOTTOM) begin
      bottom_r <= mac_blend;
    end

    if (load_out) begin
      out_pix_r    <= load_pix;
      out_status_r <= load_status;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] == STATUS_RANGE)) |-> (out_tdata == '0))
    else $error("flagged result carries a nonzero pixel");

  a_write_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> $past(in_tvalid && in_tready))
    else $error("image write without a preceding input transaction");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && step_r == STEP_RESULT && out_free)
      |=> (out_tvalid && in_tready))
    else $error("final blend did not deliver a result and release the input");

endmodule

`default_nettype wire

/* design/bliu_image_ram.sv */
// ----------------------------------------------------------------------------
// bliu_image_ram
// Single-port source image store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bliu_image_ram
  import bliu_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic                    re,
  input  wire logic [AW-1:0]           addr,
  input  wire logic signed [PIX_W-1:0] wdata,
  output logic signed [PIX_W-1:0]      rdata
);

  logic signed [PIX_W-1:0] mem [DEPTH];
  logic signed [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/bliu_mac.sv */
// ----------------------------------------------------------------------------
// bliu_mac
// Shared weight x sample accumulator; output is the floored, 16-bit blend.
// ----------------------------------------------------------------------------
`default_nettype none

module bliu_mac
  import bliu_pkg::*;
(
  input  wire logic                    clk,
  input  wire mac_ctrl_t               ctrl,
  input  wire logic signed [PIX_W-1:0] sample,
  output logic signed [PIX_W-1:0]      blend
);

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] product;
  logic signed [ACC_W-1:0] sum;

  assign product  = $signed({1'b0, ctrl.weight}) * sample;
  assign acc_base = ctrl.clear ? '0 : acc_r;
  assign sum      = acc_base + product;
  // floor by 2^FRAC_BITS, keep low 16 bits
  assign blend    = sum[FRAC_BITS +: PIX_W];

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= sum;
    end
  end

endmodule

`default_nettype wire
